### rtl/voronoi_cell_bisector_planes_top_macros.svh
// Assertion macros for the Voronoi cell bisector plane block.
// Used by the top level; no other dependencies.
`ifndef VORONOI_CELL_BISECTOR_PLANES_TOP_MACROS_SVH
`define VORONOI_CELL_BISECTOR_PLANES_TOP_MACROS_SVH

// same-cycle implication under the active-low reset
`define VCB_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under the active-low reset
`define VCB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/vcb_pkg.sv
// Shared constants, codes and control structs of the bisector plane block.
// No dependencies; imported by every module below the RAM.
`timescale 1ns / 1ps

package vcb_pkg;

    localparam int MAX_POINTS = 16;
    localparam int PT_AW      = $clog2(MAX_POINTS);
    localparam int CNT_W      = PT_AW + 1;
    localparam int MAX_PLANES = MAX_POINTS - 1;
    localparam int ACC_W      = 40;
    localparam int RD_W       = 60;
    localparam int LEN_W      = 30;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_SITE   = 2'd2;

    localparam logic [2:0] STS_PLANE = 3'd0;
    localparam logic [2:0] STS_ACK   = 3'd1;
    localparam logic [2:0] STS_NONE  = 3'd2;
    localparam logic [2:0] STS_FULL  = 3'd3;
    localparam logic [2:0] STS_BAD   = 3'd4;

    typedef struct packed {
        logic load;
        logic en;
    } mac_ctl_t;

    typedef struct packed {
        logic start;
        logic op_div;
    } rd_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rd_sts_t;

endpackage

### rtl/vcb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module vcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/vcb_mac.sv
// Shared signed multiply-accumulate unit, one product per cycle.
// Depends on vcb_pkg.
`timescale 1ns / 1ps

module vcb_mac
    import vcb_pkg::*;
(
    input  logic                    aclk,
    input  mac_ctl_t                ctl,
    input  logic signed [ACC_W-1:0] init,
    input  logic signed [17:0]      op_a,
    input  logic signed [17:0]      op_b,
    output logic signed [ACC_W-1:0] acc
);

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [35:0]      prod;

    assign prod = op_a * op_b;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            acc_reg <= init;
        end else if (ctl.en) begin
            acc_reg <= acc_reg + ACC_W'(prod);
        end
    end

    assign acc = acc_reg;

endmodule

### rtl/vcb_rootdiv.sv
// Iterative square root and restoring divider sharing one compare/subtract.
// Depends on vcb_pkg.
`timescale 1ns / 1ps

module vcb_rootdiv
    import vcb_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  rd_ctl_t          ctl,
    input  logic [RD_W-1:0]  op_a,
    input  logic [LEN_W-1:0] op_b,
    output rd_sts_t          sts,
    output logic [LEN_W-1:0] res
);

    logic [RD_W-1:0]  rem_reg, rem_next;
    logic [RD_W-1:0]  res_reg, res_next;
    logic [LEN_W-1:0] den_reg, den_next;
    logic [4:0]       i_reg, i_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             div_reg, div_next;
    logic [RD_W-1:0]  bitv;
    logic [RD_W-1:0]  sub;
    logic             ge;

    always_comb begin
        bitv = RD_W'(1) << {i_reg, 1'b0};
        sub  = div_reg ? ({{(RD_W-LEN_W){1'b0}}, den_reg} << i_reg) : (res_reg + bitv);
        ge   = rem_reg >= sub;

        rem_next  = rem_reg;
        res_next  = res_reg;
        den_next  = den_reg;
        i_next    = i_reg;
        busy_next = busy_reg;
        div_next  = div_reg;
        done_next = 1'b0;

        if (ctl.start) begin
            rem_next  = op_a;
            res_next  = '0;
            den_next  = op_b;
            div_next  = ctl.op_div;
            i_next    = ctl.op_div ? 5'd16 : 5'd29;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (ge) begin
                rem_next = rem_reg - sub;
            end
            if (div_reg) begin
                if (ge) begin
                    res_next = res_reg | (RD_W'(1) << i_reg);
                end
            end else begin
                res_next = ge ? ((res_reg >> 1) + bitv) : (res_reg >> 1);
            end
            if (i_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                i_next = i_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        res_reg <= res_next;
        den_reg <= den_next;
        i_reg   <= i_next;
        div_reg <= div_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign res      = res_reg[LEN_W-1:0];

endmodule

### rtl/voronoi_cell_bisector_planes_top.sv
// Top level: request sequencer, point and plane stores, result register.
// Depends on vcb_pkg, vcb_ram, vcb_mac, vcb_rootdiv and the macros header.
//
//   channel  dir  tdata                                  tuser        tlast
//   s_       in   x,y,z,site_index (56b)                 req_type     -
//   m_       out  normal_x/y/z,plane_offset,nbr (88b)    status       last
//
// Clear and append each give one word.
// A site request takes time for each stored point per search round, for each
// kept plane tested and for each new plane (one 30-step root and three
// 17-step divides); the shared MAC and root/divide unit set this.
// Reset is synchronous; no store clearing pass. Results wait in a one-word
// register; the sequencer holds while it is full and not taken.
`timescale 1ns / 1ps
`include "voronoi_cell_bisector_planes_top_macros.svh"

module voronoi_cell_bisector_planes_top
    import vcb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // coord_x, coord_y, coord_z, site_index, zero pad
    input  logic [1:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // normal_x, normal_y, normal_z, plane_offset,
                                   // neighbor_index, zero pad
    output logic [2:0]  m_tuser,   // status
    output logic        m_tlast
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_SITE_LD  = 5'd1;
    localparam logic [4:0] S_SRCH_INI = 5'd2;
    localparam logic [4:0] S_SRCH_RD  = 5'd3;
    localparam logic [4:0] S_SRCH_MAC = 5'd4;
    localparam logic [4:0] S_SRCH_CMP = 5'd5;
    localparam logic [4:0] S_SRCH_END = 5'd6;
    localparam logic [4:0] S_NB_LD    = 5'd7;
    localparam logic [4:0] S_BH_RD    = 5'd8;
    localparam logic [4:0] S_BH_LD    = 5'd9;
    localparam logic [4:0] S_BH_MAC   = 5'd10;
    localparam logic [4:0] S_BH_CMP   = 5'd11;
    localparam logic [4:0] S_NRM_ABS  = 5'd12;
    localparam logic [4:0] S_NRM_SH   = 5'd13;
    localparam logic [4:0] S_NRM_SQ   = 5'd14;
    localparam logic [4:0] S_ROOT_GO  = 5'd15;
    localparam logic [4:0] S_ROOT_WT  = 5'd16;
    localparam logic [4:0] S_DIV_GO   = 5'd17;
    localparam logic [4:0] S_DIV_WT   = 5'd18;
    localparam logic [4:0] S_DOT      = 5'd19;
    localparam logic [4:0] S_OFF      = 5'd20;
    localparam logic [4:0] S_FINISH   = 5'd21;
    localparam logic [4:0] S_SINGLE   = 5'd22;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

    logic [4:0]              state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [15:0]      s_reg [0:2];
    logic signed [15:0]      s_next [0:2];
    logic [CNT_W-1:0]        j_reg, j_next;
    logic [1:0]              c_reg, c_next;
    logic                    found_reg, found_next;
    logic signed [ACC_W-1:0] best_reg, best_next;
    logic [PT_AW-1:0]        bi_reg, bi_next;
    logic [MAX_POINTS-1:0]   vis_reg, vis_next;
    logic [PT_AW-1:0]        kept_reg, kept_next;
    logic [PT_AW-1:0]        k_reg, k_next;
    logic signed [16:0]      d_reg [0:2];
    logic signed [16:0]      d_next [0:2];
    logic signed [17:0]      sm_reg [0:2];
    logic signed [17:0]      sm_next [0:2];
    logic [16:0]             m_reg [0:2];
    logic [16:0]             m_next [0:2];
    logic [LEN_W-1:0]        len_reg, len_next;
    logic signed [15:0]      n_reg [0:2];
    logic signed [15:0]      n_next [0:2];
    logic [83:0]             pend_reg, pend_next;
    logic                    pend_vld_reg, pend_vld_next;
    logic [2:0]              st_reg, st_next;
    logic [PT_AW-1:0]        pt_ra_reg, pt_ra_next;
    logic [PT_AW-1:0]        pl_ra_reg, pl_ra_next;
    logic                    out_vld_reg, out_vld_next;
    logic [83:0]             out_data_reg, out_data_next;
    logic [2:0]              out_st_reg, out_st_next;
    logic                    out_last_reg, out_last_next;

    logic                    out_free;
    logic                    pt_we;
    logic [47:0]             pt_rdata;
    logic                    pl_we;
    logic [79:0]             pl_wdata;
    logic [79:0]             pl_rdata;
    logic signed [15:0]      pt_c [0:2];
    logic signed [16:0]      diff_c [0:2];
    logic signed [17:0]      sum_c [0:2];
    logic signed [15:0]      pl_n [0:2];
    logic signed [31:0]      pl_off;
    mac_ctl_t                mac_ctl;
    logic signed [ACC_W-1:0] mac_init;
    logic signed [17:0]      mac_a, mac_b;
    logic signed [ACC_W-1:0] acc;
    rd_ctl_t                 rd_ctl;
    rd_sts_t                 rd_sts;
    logic [RD_W-1:0]         rd_a;
    logic [LEN_W-1:0]        rd_res;
    logic [16:0]             mx;
    logic [15:0]             qc;
    logic signed [40:0]      off_t;
    logic signed [40:0]      off_h;
    logic signed [31:0]      off_sat;
    logic                    status_word;
    logic                    out_stall;

    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !out_vld_reg || m_tready;

    vcb_ram #(.WIDTH(48), .DEPTH(MAX_POINTS)) u_pt_ram (
        .aclk  (aclk),
        .we    (pt_we),
        .waddr (cnt_reg[PT_AW-1:0]),
        .wdata (s_tdata[47:0]),
        .raddr (pt_ra_next),
        .rdata (pt_rdata)
    );

    vcb_ram #(.WIDTH(80), .DEPTH(MAX_POINTS)) u_pl_ram (
        .aclk  (aclk),
        .we    (pl_we),
        .waddr (kept_reg),
        .wdata (pl_wdata),
        .raddr (pl_ra_next),
        .rdata (pl_rdata)
    );

    vcb_mac u_mac (
        .aclk (aclk),
        .ctl  (mac_ctl),
        .init (mac_init),
        .op_a (mac_a),
        .op_b (mac_b),
        .acc  (acc)
    );

    vcb_rootdiv u_rootdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (rd_ctl),
        .op_a    (rd_a),
        .op_b    (len_reg),
        .sts     (rd_sts),
        .res     (rd_res)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pt_c[i]   = pt_rdata[16*i +: 16];
            diff_c[i] = {pt_c[i][15], pt_c[i]} - {s_reg[i][15], s_reg[i]};
            sum_c[i]  = {{2{pt_c[i][15]}}, pt_c[i]} + {{2{s_reg[i][15]}}, s_reg[i]};
            pl_n[i]   = pl_rdata[16*i +: 16];
        end
        pl_off = pl_rdata[79:48];

        mx = (m_reg[0] > m_reg[1]) ? m_reg[0] : m_reg[1];
        mx = (m_reg[2] > mx) ? m_reg[2] : mx;

        qc = (rd_res[16:0] > 17'd16384) ? 16'd16384 : rd_res[15:0];

        off_t = 41'sd1 - {acc[ACC_W-1], acc};
        off_h = off_t >>> 1;
        if (off_h > 41'sd2147483647) begin
            off_sat = 32'sh7fffffff;
        end else if (off_h < -41'sd2147483648) begin
            off_sat = 32'sh80000000;
        end else begin
            off_sat = off_h[31:0];
        end

        case (state_reg)
            S_SRCH_MAC: begin
                mac_a = {diff_c[c_reg][16], diff_c[c_reg]};
                mac_b = {diff_c[c_reg][16], diff_c[c_reg]};
            end
            S_BH_MAC: begin
                mac_a = {{2{pl_n[c_reg][15]}}, pl_n[c_reg]};
                mac_b = sm_reg[c_reg];
            end
            S_NRM_SQ: begin
                mac_a = {1'b0, m_reg[c_reg]};
                mac_b = {1'b0, m_reg[c_reg]};
            end
            S_DOT: begin
                mac_a = {{2{n_reg[c_reg][15]}}, n_reg[c_reg]};
                mac_b = sm_reg[c_reg];
            end
            default: begin
                mac_a = '0;
                mac_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        s_next        = s_reg;
        j_next        = j_reg;
        c_next        = c_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        bi_next       = bi_reg;
        vis_next      = vis_reg;
        kept_next     = kept_reg;
        k_next        = k_reg;
        d_next        = d_reg;
        sm_next       = sm_reg;
        m_next        = m_reg;
        len_next      = len_reg;
        n_next        = n_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        st_next       = st_reg;
        pt_ra_next    = pt_ra_reg;
        pl_ra_next    = pl_ra_reg;
        out_vld_next  = m_tready ? 1'b0 : out_vld_reg;
        out_data_next = out_data_reg;
        out_st_next   = out_st_reg;
        out_last_next = out_last_reg;
        pt_we         = 1'b0;
        pl_we         = 1'b0;
        pl_wdata      = {off_sat, n_reg[2], n_reg[1], n_reg[0]};
        mac_ctl       = '0;
        mac_init      = '0;
        rd_ctl        = '0;
        rd_a          = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    case (s_tuser)
                        REQ_CLEAR: begin
                            cnt_next   = '0;
                            st_next    = STS_ACK;
                            state_next = S_SINGLE;
                        end
                        REQ_APPEND: begin
                            if (cnt_reg == CNT_W'(MAX_POINTS)) begin
                                st_next = STS_FULL;
                            end else begin
                                pt_we    = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                                st_next  = STS_ACK;
                            end
                            state_next = S_SINGLE;
                        end
                        REQ_SITE: begin
                            if ({1'b0, s_tdata[51:48]} >= cnt_reg) begin
                                st_next    = STS_BAD;
                                state_next = S_SINGLE;
                            end else begin
                                pt_ra_next = s_tdata[51:48];
                                state_next = S_SITE_LD;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SITE_LD: begin
                s_next        = pt_c;
                vis_next      = MAX_POINTS'(1) << pt_ra_reg;
                kept_next     = '0;
                pend_vld_next = 1'b0;
                state_next    = S_SRCH_INI;
            end
            S_SRCH_INI: begin
                j_next     = '0;
                found_next = 1'b0;
                state_next = S_SRCH_RD;
            end
            S_SRCH_RD: begin
                if (j_reg == cnt_reg) begin
                    state_next = S_SRCH_END;
                end else if (vis_reg[j_reg[PT_AW-1:0]]) begin
                    j_next = j_reg + 1'b1;
                end else begin
                    pt_ra_next  = j_reg[PT_AW-1:0];
                    mac_ctl.load = 1'b1;
                    c_next      = 2'd0;
                    state_next  = S_SRCH_MAC;
                end
            end
            S_SRCH_MAC: begin
                mac_ctl.en = 1'b1;
                c_next     = c_reg + 2'd1;
                if (c_reg == 2'd2) begin
                    state_next = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                if (!found_reg || (acc < best_reg)) begin
                    best_next  = acc;
                    bi_next    = j_reg[PT_AW-1:0];
                    found_next = 1'b1;
                end
                j_next     = j_reg + 1'b1;
                state_next = S_SRCH_RD;
            end
            S_SRCH_END: begin
                if (!found_reg || (kept_reg == PT_AW'(MAX_PLANES))) begin
                    state_next = S_FINISH;
                end else begin
                    vis_next[bi_reg] = 1'b1;
                    if (best_reg == '0) begin
                        state_next = S_SRCH_INI;
                    end else begin
                        pt_ra_next = bi_reg;
                        state_next = S_NB_LD;
                    end
                end
            end
            S_NB_LD: begin
                d_next     = diff_c;
                sm_next    = sum_c;
                k_next     = '0;
                state_next = S_BH_RD;
            end
            S_BH_RD: begin
                if (k_reg == kept_reg) begin
                    state_next = S_NRM_ABS;
                end else begin
                    pl_ra_next = k_reg;
                    state_next = S_BH_LD;
                end
            end
            S_BH_LD: begin
                mac_ctl.load = 1'b1;
                mac_init     = {{(ACC_W-33){pl_off[31]}}, pl_off, 1'b0};
                c_next       = 2'd0;
                state_next   = S_BH_MAC;
            end
            S_BH_MAC: begin
                mac_ctl.en = 1'b1;
                c_next     = c_reg + 2'd1;
                if (c_reg == 2'd2) begin
                    state_next = S_BH_CMP;
                end
            end
            S_BH_CMP: begin
                if (!acc[ACC_W-1]) begin
                    state_next = S_SRCH_INI;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_BH_RD;
                end
            end
            S_NRM_ABS: begin
                for (int i = 0; i < 3; i++) begin
                    m_next[i] = d_reg[i][16] ? 17'(-d_reg[i]) : 17'(d_reg[i]);
                end
                state_next = S_NRM_SH;
            end
            S_NRM_SH: begin
                if (mx < 17'd16384) begin
                    for (int i = 0; i < 3; i++) begin
                        m_next[i] = m_reg[i] << 1;
                    end
                end else if (mx >= 17'd32768) begin
                    for (int i = 0; i < 3; i++) begin
                        m_next[i] = m_reg[i] >> 1;
                    end
                end else begin
                    mac_ctl.load = 1'b1;
                    c_next       = 2'd0;
                    state_next   = S_NRM_SQ;
                end
            end
            S_NRM_SQ: begin
                mac_ctl.en = 1'b1;
                c_next     = c_reg + 2'd1;
                if (c_reg == 2'd2) begin
                    state_next = S_ROOT_GO;
                end
            end
            S_ROOT_GO: begin
                rd_ctl.start = 1'b1;
                rd_a         = {acc[31:0], 28'd0};
                state_next   = S_ROOT_WT;
            end
            S_ROOT_WT: begin
                if (rd_sts.done) begin
                    len_next   = rd_res;
                    c_next     = 2'd0;
                    state_next = S_DIV_GO;
                end
            end
            S_DIV_GO: begin
                rd_ctl.start  = 1'b1;
                rd_ctl.op_div = 1'b1;
                rd_a          = {15'd0, m_reg[c_reg], 28'd0}
                              + {31'd0, len_reg[LEN_W-1:1]};
                state_next    = S_DIV_WT;
            end
            S_DIV_WT: begin
                if (rd_sts.done) begin
                    n_next[c_reg] = d_reg[c_reg][16] ? 16'(-qc) : qc;
                    if (c_reg == 2'd2) begin
                        mac_ctl.load = 1'b1;
                        c_next       = 2'd0;
                        state_next   = S_DOT;
                    end else begin
                        c_next     = c_reg + 2'd1;
                        state_next = S_DIV_GO;
                    end
                end
            end
            S_DOT: begin
                mac_ctl.en = 1'b1;
                c_next     = c_reg + 2'd1;
                if (c_reg == 2'd2) begin
                    state_next = S_OFF;
                end
            end
            S_OFF: begin
                if (!pend_vld_reg || out_free) begin
                    if (pend_vld_reg) begin
                        out_vld_next  = 1'b1;
                        out_data_next = pend_reg;
                        out_st_next   = STS_PLANE;
                        out_last_next = 1'b0;
                    end
                    pend_next     = {bi_reg, off_sat, n_reg[2], n_reg[1], n_reg[0]};
                    pend_vld_next = 1'b1;
                    pl_we         = 1'b1;
                    kept_next     = kept_reg + 1'b1;
                    state_next    = S_SRCH_INI;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    out_vld_next  = 1'b1;
                    out_last_next = 1'b1;
                    if (pend_vld_reg) begin
                        out_data_next = pend_reg;
                        out_st_next   = STS_PLANE;
                    end else begin
                        out_data_next = '0;
                        out_st_next   = STS_NONE;
                    end
                    pend_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            S_SINGLE: begin
                if (out_free) begin
                    out_vld_next  = 1'b1;
                    out_data_next = '0;
                    out_st_next   = st_reg;
                    out_last_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            kept_reg     <= '0;
            vis_reg      <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            kept_reg     <= kept_next;
            vis_reg      <= vis_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
        s_reg        <= s_next;
        j_reg        <= j_next;
        c_reg        <= c_next;
        found_reg    <= found_next;
        best_reg     <= best_next;
        bi_reg       <= bi_next;
        k_reg        <= k_next;
        d_reg        <= d_next;
        sm_reg       <= sm_next;
        m_reg        <= m_next;
        len_reg      <= len_next;
        n_reg        <= n_next;
        pend_reg     <= pend_next;
        st_reg       <= st_next;
        pt_ra_reg    <= pt_ra_next;
        pl_ra_reg    <= pl_ra_next;
        out_data_reg <= out_data_next;
        out_st_reg   <= out_st_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'd0, out_data_reg};
    assign m_tuser  = out_st_reg;
    assign m_tlast  = out_last_reg;

    assign status_word = m_tvalid && (m_tuser != STS_PLANE);
    assign out_stall   = m_tvalid && !m_tready;

    `VCB_ASSERT_IMPLY(a_status_last, aclk, aresetn, status_word, m_tlast, "status word not last")
    `VCB_ASSERT_IMPLY(a_status_zero, aclk, aresetn, status_word, m_tdata == '0, "data on status")
    `VCB_ASSERT_IMPLY(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CNT_MAX, "count overflow")
    `VCB_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_tvalid, "result word dropped")

endmodule
